/* hw/rtl/bpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpr_pkg;

    // Register indexes on the configuration write channel.
    typedef enum logic [7:0] {
        CFG_SEARCH_PATTERN      = 8'd0,
        CFG_SEARCH_LENGTH       = 8'd1,
        CFG_REPLACEMENT_PATTERN = 8'd2,
        CFG_REPLACEMENT_LENGTH  = 8'd3
    } bpr_cfg_index_t;

    // Sideband that goes with one loaded result list.
    typedef struct packed {
        logic present;   // 0 only for the empty end-of-stream marker
        logic last;      // the list closes the stream
    } bpr_ctl_t;

endpackage : bpr_pkg

`default_nettype wire

/* hw/rtl/bpr_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpr_core
    import bpr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int WCW         = $clog2(MAX_PATTERN + 1),
    parameter int LCW         = $clog2(MAX_PATTERN + 2)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [WCW-1:0]               search_len,
    input  wire logic [WCW-1:0]               repl_len,
    input  wire logic [63:0]                  search_pattern,
    input  wire logic [63:0]                  replacement_pattern,
    input  wire logic                         clear_window,
    input  wire logic                         step,
    input  wire logic [7:0]                   in_byte,
    input  wire logic                         in_eoi,
    output logic      [MAX_PATTERN:0][7:0]    list_bytes,
    output logic      [LCW-1:0]               list_count,
    output bpr_ctl_t                          list_ctl
);

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [WCW-1:0]              count_reg;
    logic [WCW-1:0]              count_next;

    logic [MAX_PATTERN-1:0][7:0] win_ins;
    logic [WCW-1:0]              wc;
    logic [WCW-1:0]              wc1;
    logic                        full;
    logic                        match;

    // Window with the new byte written at its fill position.
    always_comb
    begin
        wc  = (count_reg >= search_len) ? '0 : count_reg;
        wc1 = wc + WCW'(1);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_ins[i] = (WCW'(i) == wc) ? in_byte : win_reg[i];
        end
        full  = (wc1 == search_len);
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((WCW'(i) < search_len) && (win_ins[i] != search_pattern[8*i +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        list_bytes       = '0;
        list_count       = '0;
        list_ctl.present = 1'b1;
        list_ctl.last    = in_eoi;
        win_next         = win_ins;
        count_next       = wc1;

        if (search_len == '0)
        begin
            // Insert mode: replacement, then the byte itself.
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                list_bytes[i] = (WCW'(i) < repl_len) ? replacement_pattern[8*i +: 8] : in_byte;
            end
            list_bytes[MAX_PATTERN] = in_byte;
            list_count = LCW'(repl_len) + LCW'(1);
            count_next = '0;
        end
        else if (full && match)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                list_bytes[i] = replacement_pattern[8*i +: 8];
            end
            list_count = LCW'(repl_len);
            count_next = '0;
        end
        else if (full)
        begin
            // Oldest byte leaves; at end of stream the rest follows it.
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                list_bytes[i] = win_ins[i];
            end
            list_count = in_eoi ? LCW'(search_len) : LCW'(1);
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                win_next[i] = win_ins[i + 1];
            end
            count_next = search_len - WCW'(1);
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                list_bytes[i] = win_ins[i];
            end
            list_count = in_eoi ? LCW'(wc1) : '0;
        end

        if (in_eoi)
        begin
            count_next = '0;
            if (list_count == '0)
            begin
                // Nothing to send, but the end of the stream must still be marked.
                list_bytes[0]    = '0;
                list_count       = LCW'(1);
                list_ctl.present = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clear_window)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

endmodule : bpr_core

`default_nettype wire

/* hw/rtl/bpr_emit.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpr_emit
    import bpr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int LCW         = $clog2(MAX_PATTERN + 2)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire logic [MAX_PATTERN:0][7:0]  list_bytes,
    input  wire logic [LCW-1:0]             list_count,
    input  wire bpr_ctl_t                   list_ctl,
    output logic                            can_load,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [7:0]                      m_axis_tdata,
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic [MAX_PATTERN:0][7:0] list_reg;
    logic [MAX_PATTERN:0][7:0] list_next;
    logic [LCW-1:0]            count_reg;
    bpr_ctl_t                  ctl_reg;
    logic                      xfer;

    assign xfer     = m_axis_tvalid && m_axis_tready;
    assign can_load = (count_reg == '0) || ((count_reg == LCW'(1)) && m_axis_tready);

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = list_reg[0];
    assign m_axis_tuser  = ctl_reg.present;
    assign m_axis_tlast  = ctl_reg.last && (count_reg == LCW'(1));

    always_comb
    begin
        list_next = list_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            list_next[i] = list_reg[i + 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            list_reg <= list_bytes;
            ctl_reg  <= list_ctl;
        end
        else if (xfer)
        begin
            list_reg <= list_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= list_count;
        end
        else if (xfer)
        begin
            count_reg <= count_reg - LCW'(1);
        end
    end

endmodule : bpr_emit

`default_nettype wire

/* hw/rtl/byte_pattern_replacer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel        Direction  Transfer when             Payload
// s_axis         in         s_axis_tvalid & tready    tdata: data_byte, tlast: end_of_input
// m_axis         out        m_axis_tvalid & tready    tdata: out_byte, tuser: byte_present,
//                                                     tlast: last
// cfg            in         cfg_valid & cfg_ready     cfg_index: register, cfg_data: value
//
// An input byte is taken into an input register, then turned combinationally into a list of
// up to MAX_PATTERN + 1 results that is loaded into the output shift register.
// The output side sends one result per cycle while m_axis_tready is high, so an item with n
// results holds the output until all n are sent; items with zero or one result flow at one per cycle then.
// The first result of an item is presented on m_axis from the output shift register.
// rst_n sets the configuration registers to their defaults (search length one) and empties the window.
// Back-pressure on m_axis stalls the input register, which then drops s_axis_tready.

module byte_pattern_replacer_unit
    import bpr_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  wire logic        s_axis_tlast,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic             m_axis_tuser,    // [0] byte_present
    output logic             m_axis_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int WCW = $clog2(MAX_PATTERN + 1);
    localparam int LCW = $clog2(MAX_PATTERN + 2);

    // Configuration registers.
    logic [63:0] search_pattern_reg;
    logic [3:0]  search_length_reg;
    logic [63:0] replacement_pattern_reg;
    logic [3:0]  replacement_length_reg;
    logic        cfg_xfer;
    logic        clear_window;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eoi_reg;

    logic [WCW-1:0]            search_len;
    logic [WCW-1:0]            repl_len;
    logic                      step;
    logic                      can_load;
    logic [MAX_PATTERN:0][7:0] list_bytes;
    logic [LCW-1:0]            list_count;
    bpr_ctl_t                  list_ctl;

    // The user must issue writes only while the block is idle; not enforced, the port is always open.
    assign cfg_ready    = 1'b1;
    assign cfg_xfer     = cfg_valid && cfg_ready;
    assign clear_window = cfg_xfer && (cfg_index == CFG_SEARCH_LENGTH);

    // Lengths beyond the window size saturate.
    assign search_len = (search_length_reg > MAX_PATTERN) ? WCW'(MAX_PATTERN)
                                                          : search_length_reg[WCW-1:0];
    assign repl_len   = (replacement_length_reg > MAX_PATTERN) ? WCW'(MAX_PATTERN)
                                                               : replacement_length_reg[WCW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_pattern_reg      <= '0;
            search_length_reg       <= 4'd1;
            replacement_pattern_reg <= '0;
            replacement_length_reg  <= '0;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                CFG_SEARCH_PATTERN:      search_pattern_reg      <= cfg_data;
                CFG_SEARCH_LENGTH:       search_length_reg       <= cfg_data[3:0];
                CFG_REPLACEMENT_PATTERN: replacement_pattern_reg <= cfg_data;
                CFG_REPLACEMENT_LENGTH:  replacement_length_reg  <= cfg_data[3:0];
                default:                 ;
            endcase
        end
    end

    // The held item is processed as soon as the output side can take its result list.
    assign step          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    bpr_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .WCW         (WCW),
        .LCW         (LCW)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .search_len          (search_len),
        .repl_len            (repl_len),
        .search_pattern      (search_pattern_reg),
        .replacement_pattern (replacement_pattern_reg),
        .clear_window        (clear_window),
        .step                (step),
        .in_byte             (in_byte_reg),
        .in_eoi              (in_eoi_reg),
        .list_bytes          (list_bytes),
        .list_count          (list_count),
        .list_ctl            (list_ctl)
    );

    bpr_emit #(
        .MAX_PATTERN (MAX_PATTERN),
        .LCW         (LCW)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step),
        .list_bytes    (list_bytes),
        .list_count    (list_count),
        .list_ctl      (list_ctl),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule : byte_pattern_replacer_unit

`default_nettype wire
